>>> sv/mlbc_pkg.sv
// Shared constants and command codes for the multi-LED blink controller.
package mlbc_pkg;

    localparam int LED_COUNT = 4;
    localparam int LEVELS_W  = 4;
    localparam int CMD_W     = 3;
    localparam int SEL_W     = 2;
    localparam int SHORT_W   = 16;
    localparam int STAMP_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_OFF    = 3'd0,
        CMD_ON     = 3'd1,
        CMD_TOGGLE = 3'd2,
        CMD_BLINK  = 3'd3,
        CMD_POLL   = 3'd4
    } cmd_t;

endpackage

>>> sv/multi_led_blink_controller.sv
// Multi-LED blink controller: command register, per-LED blink state and result register.
//
// Usage
//   Input channel (in_valid / in_stall) carries one request: a command for the LED
//   named by led_select (off, on, toggle, start blink) or a poll that carries the
//   current time in now. Start blink also uses on_time, blink_period, repeat_count
//   and now. Unknown commands leave every LED as it is.
//   Output channel (out_valid / out_stall) returns one result per request: the
//   four pin levels in led_levels after that request took effect.
//   Flow: an accepted request is latched into the command register, evaluated
//   against the LED state, and its result is written to the result register on
//   led_levels once that register is free.
//   Throughput: one request per cycle while out_stall is low; all LEDs are updated
//   in parallel by one level of 32-bit adders and compares between the two registers.
//   Reset (rst_n low, asynchronous): all pins low, all blink state zero, both
//   pipeline stages empty.
//   Stall: while out_stall holds a waiting result, the command register keeps its
//   request and in_stall rises only once that register is also occupied.
module multi_led_blink_controller
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mlbc_pkg::CMD_W-1:0]     command,
    input  logic [mlbc_pkg::SEL_W-1:0]     led_select,
    input  logic [mlbc_pkg::SHORT_W-1:0]   on_time,
    input  logic [mlbc_pkg::SHORT_W-1:0]   blink_period,
    input  logic [mlbc_pkg::SHORT_W-1:0]   repeat_count,
    input  logic [mlbc_pkg::STAMP_W-1:0]   now,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mlbc_pkg::LEVELS_W-1:0]  led_levels
);

    // command register
    logic                          s1_valid_reg;
    logic [mlbc_pkg::CMD_W-1:0]    command_reg;
    logic [mlbc_pkg::SEL_W-1:0]    sel_reg;
    logic [mlbc_pkg::SHORT_W-1:0]  on_in_reg;
    logic [mlbc_pkg::SHORT_W-1:0]  period_in_reg;
    logic [mlbc_pkg::SHORT_W-1:0]  repeat_in_reg;
    logic [mlbc_pkg::STAMP_W-1:0]  now_reg;

    // per-LED state
    logic [mlbc_pkg::LED_COUNT-1:0] pin_level_reg;
    logic [mlbc_pkg::LED_COUNT-1:0] pin_level_next;
    logic [mlbc_pkg::SHORT_W-1:0]   on_time_reg    [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::SHORT_W-1:0]   on_time_next   [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::SHORT_W-1:0]   period_reg     [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::SHORT_W-1:0]   period_next    [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::SHORT_W-1:0]   count_reg      [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::SHORT_W-1:0]   count_next     [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::STAMP_W-1:0]   stamp_reg      [mlbc_pkg::LED_COUNT];
    logic [mlbc_pkg::STAMP_W-1:0]   stamp_next     [mlbc_pkg::LED_COUNT];

    // result register
    logic                           out_valid_reg;
    logic [mlbc_pkg::LEVELS_W-1:0]  led_levels_reg;
    logic [mlbc_pkg::LEVELS_W-1:0]  led_levels_next;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign led_levels = led_levels_reg;

    always_comb
    begin
        logic [mlbc_pkg::STAMP_W-1:0]                     period_end;
        logic [mlbc_pkg::STAMP_W-1:0]                     on_end;
        logic [mlbc_pkg::SHORT_W-1:0]                     per_after;
        logic                                             hit;
        logic [mlbc_pkg::LED_COUNT+mlbc_pkg::LEVELS_W-1:0] wide;

        pin_level_next = pin_level_reg;
        for (int i = 0; i < mlbc_pkg::LED_COUNT; i++)
        begin
            on_time_next[i] = on_time_reg[i];
            period_next[i]  = period_reg[i];
            count_next[i]   = count_reg[i];
            stamp_next[i]   = stamp_reg[i];

            period_end = stamp_reg[i] + {{(mlbc_pkg::STAMP_W-mlbc_pkg::SHORT_W){1'b0}},
                                          period_reg[i]};
            on_end     = stamp_reg[i] + {{(mlbc_pkg::STAMP_W-mlbc_pkg::SHORT_W){1'b0}},
                                          on_time_reg[i]};
            hit        = (int'(sel_reg) == i);
            per_after  = period_reg[i];

            case (command_reg)
                mlbc_pkg::CMD_OFF:
                begin
                    if (hit)
                        pin_level_next[i] = 1'b0;
                end
                mlbc_pkg::CMD_ON:
                begin
                    if (hit)
                        pin_level_next[i] = 1'b1;
                end
                mlbc_pkg::CMD_TOGGLE:
                begin
                    if (hit)
                        pin_level_next[i] = !pin_level_reg[i];
                end
                mlbc_pkg::CMD_BLINK:
                begin
                    if (hit)
                    begin
                        pin_level_next[i] = 1'b1;
                        on_time_next[i]   = on_in_reg;
                        period_next[i]    = period_in_reg;
                        count_next[i]     = repeat_in_reg;
                        stamp_next[i]     = now_reg;
                    end
                end
                mlbc_pkg::CMD_POLL:
                begin
                    if (period_reg[i] != '0)
                    begin
                        if (period_end < now_reg)
                        begin
                            if (count_reg[i] != '0)
                            begin
                                count_next[i] = count_reg[i] - 1'b1;
                                // last repeat done: blinking stops, pin keeps its level
                                if (count_reg[i] == mlbc_pkg::SHORT_W'(1))
                                    per_after = '0;
                            end
                            period_next[i] = per_after;
                            if (per_after != '0)
                            begin
                                pin_level_next[i] = 1'b1;
                                stamp_next[i]     = now_reg;
                            end
                        end
                        else if (on_end < now_reg)
                        begin
                            pin_level_next[i] = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // LEDs beyond the count read low; only the first four are reported
        wide            = {{mlbc_pkg::LEVELS_W{1'b0}}, pin_level_next};
        led_levels_next = wide[mlbc_pkg::LEVELS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            command_reg   <= command;
            sel_reg       <= led_select;
            on_in_reg     <= on_time;
            period_in_reg <= blink_period;
            repeat_in_reg <= repeat_count;
            now_reg       <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_level_reg <= '0;
            for (int i = 0; i < mlbc_pkg::LED_COUNT; i++)
            begin
                on_time_reg[i] <= '0;
                period_reg[i]  <= '0;
                count_reg[i]   <= '0;
                stamp_reg[i]   <= '0;
            end
        end
        else if (s1_fire)
        begin
            pin_level_reg <= pin_level_next;
            for (int i = 0; i < mlbc_pkg::LED_COUNT; i++)
            begin
                on_time_reg[i] <= on_time_next[i];
                period_reg[i]  <= period_next[i];
                count_reg[i]   <= count_next[i];
                stamp_reg[i]   <= stamp_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            led_levels_reg <= led_levels_next;
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage had room");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(pin_level_reg))
        else $error("pin levels changed without a request");

    a_poll_keeps_on_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && command_reg == mlbc_pkg::CMD_POLL) |=> $stable(on_time_reg[0]))
        else $error("poll altered a stored on-time");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("request evaluated but no result presented");

endmodule

>>> verif/multi_led_blink_controller_tb.sv
// Self-checking testbench for the multi-LED blink controller: directed and random requests.
module multi_led_blink_controller_tb;

    localparam logic [mlbc_pkg::CMD_W-1:0] CMD_RSVD_LAST = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // Tracks the expected pin levels and the results still owed by the block.
    class led_level_tracker;
        bit [mlbc_pkg::LED_COUNT-1:0]   pin_on;
        bit [mlbc_pkg::SHORT_W-1:0]     on_len       [mlbc_pkg::LED_COUNT];
        bit [mlbc_pkg::SHORT_W-1:0]     period_len   [mlbc_pkg::LED_COUNT];
        bit [mlbc_pkg::SHORT_W-1:0]     repeats_left [mlbc_pkg::LED_COUNT];
        bit [mlbc_pkg::STAMP_W-1:0]     stamp        [mlbc_pkg::LED_COUNT];
        bit [mlbc_pkg::LEVELS_W-1:0]    levels_due[$];
        int                             mismatches;

        function void note_request(bit [mlbc_pkg::CMD_W-1:0] cmd,
                                   bit [mlbc_pkg::SEL_W-1:0] sel,
                                   bit [mlbc_pkg::SHORT_W-1:0] on_t,
                                   bit [mlbc_pkg::SHORT_W-1:0] per,
                                   bit [mlbc_pkg::SHORT_W-1:0] rep,
                                   bit [mlbc_pkg::STAMP_W-1:0] t);
            bit [mlbc_pkg::STAMP_W-1:0]  period_end;
            bit [mlbc_pkg::STAMP_W-1:0]  on_end;
            bit [mlbc_pkg::LEVELS_W-1:0] packed_levels;
            int                          i;
            if (cmd == mlbc_pkg::CMD_POLL) begin
                for (i = 0; i < mlbc_pkg::LED_COUNT; i++) begin
                    if (period_len[i] != 0) begin
                        // sums wrap at 32 bits
                        period_end = stamp[i] + mlbc_pkg::STAMP_W'(period_len[i]);
                        on_end     = stamp[i] + mlbc_pkg::STAMP_W'(on_len[i]);
                        if (period_end < t) begin
                            if (repeats_left[i] != 0) begin
                                repeats_left[i]--;
                                if (repeats_left[i] == 0)
                                    period_len[i] = '0;
                            end
                            if (period_len[i] != 0) begin
                                pin_on[i] = 1'b1;
                                stamp[i]  = t;
                            end
                        end
                        else if (on_end < t) begin
                            pin_on[i] = 1'b0;
                        end
                    end
                end
            end
            else if (sel < mlbc_pkg::LED_COUNT) begin
                case (cmd)
                    mlbc_pkg::CMD_OFF:    pin_on[sel] = 1'b0;
                    mlbc_pkg::CMD_ON:     pin_on[sel] = 1'b1;
                    mlbc_pkg::CMD_TOGGLE: pin_on[sel] = ~pin_on[sel];
                    mlbc_pkg::CMD_BLINK:
                    begin
                        pin_on[sel]       = 1'b1;
                        on_len[sel]       = on_t;
                        period_len[sel]   = per;
                        repeats_left[sel] = rep;
                        stamp[sel]        = t;
                    end
                    default: ;
                endcase
            end
            packed_levels = '0;
            for (i = 0; i < mlbc_pkg::LED_COUNT && i < mlbc_pkg::LEVELS_W; i++)
                packed_levels[i] = pin_on[i];
            levels_due.push_back(packed_levels);
        endfunction

        function void check_levels(bit [mlbc_pkg::LEVELS_W-1:0] got);
            bit [mlbc_pkg::LEVELS_W-1:0] want;
            if (levels_due.size() == 0) begin
                $error("led_levels: result with no request pending, actual %h", got);
                mismatches++;
            end
            else begin
                want = levels_due.pop_front();
                if (got !== want) begin
                    $error("led_levels: expected %h actual %h", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [mlbc_pkg::CMD_W-1:0]     command;
    logic [mlbc_pkg::SEL_W-1:0]     led_select;
    logic [mlbc_pkg::SHORT_W-1:0]   on_time;
    logic [mlbc_pkg::SHORT_W-1:0]   blink_period;
    logic [mlbc_pkg::SHORT_W-1:0]   repeat_count;
    logic [mlbc_pkg::STAMP_W-1:0]   now;
    logic                           out_valid;
    logic                           out_stall;
    logic [mlbc_pkg::LEVELS_W-1:0]  led_levels;

    led_level_tracker               levels = new();
    bit                             tx_burst;
    bit                             rx_burst;
    bit                             hold_go;
    logic                           out_hold;
    bit [mlbc_pkg::STAMP_W-1:0]     wall_clock;
    int                             cycle_count;

    multi_led_blink_controller i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .led_select   (led_select),
        .on_time      (on_time),
        .blink_period (blink_period),
        .repeat_count (repeat_count),
        .now          (now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .led_levels   (led_levels)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_request(logic [mlbc_pkg::CMD_W-1:0] cmd,
                                logic [mlbc_pkg::SEL_W-1:0] sel,
                                logic [mlbc_pkg::SHORT_W-1:0] on_t,
                                logic [mlbc_pkg::SHORT_W-1:0] per,
                                logic [mlbc_pkg::SHORT_W-1:0] rep,
                                logic [mlbc_pkg::STAMP_W-1:0] t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        // valid stays high across back-to-back requests
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        led_select   <= sel;
        on_time      <= on_t;
        blink_period <= per;
        repeat_count <= rep;
        now          <= t;
        do @(posedge clk); while (in_stall);
        levels.note_request(cmd, sel, on_t, per, rep, t);
        if ($urandom_range(0, 39) == 0)
            tx_burst = ~tx_burst;
    endtask

    // Mostly well-formed blink traffic against a slowly advancing clock, some noise.
    task automatic send_random_request();
        int                           pick;
        logic [mlbc_pkg::CMD_W-1:0]   cmd;
        logic [mlbc_pkg::SEL_W-1:0]   sel;
        logic [mlbc_pkg::SHORT_W-1:0] on_t;
        logic [mlbc_pkg::SHORT_W-1:0] per;
        logic [mlbc_pkg::SHORT_W-1:0] rep;
        logic [mlbc_pkg::STAMP_W-1:0] t;
        pick = $urandom_range(0, 99);
        sel  = mlbc_pkg::SEL_W'($urandom_range(0, 3));
        on_t = mlbc_pkg::SHORT_W'($urandom);
        per  = mlbc_pkg::SHORT_W'($urandom);
        rep  = mlbc_pkg::SHORT_W'($urandom);
        t    = $urandom;
        cmd  = mlbc_pkg::CMD_W'($urandom_range(0, 7));
        if (pick >= 8)
        begin
            t = wall_clock;
            if (pick < 50)
            begin
                cmd        = mlbc_pkg::CMD_POLL;
                wall_clock = wall_clock + $urandom_range(0, 25);
                t          = wall_clock;
            end
            else if (pick < 66)
            begin
                cmd = mlbc_pkg::CMD_BLINK;
                if ($urandom_range(0, 9) == 0)
                    per = '0;
                else if ($urandom_range(0, 19) != 0)
                    per = mlbc_pkg::SHORT_W'($urandom_range(1, 40));
                on_t = mlbc_pkg::SHORT_W'($urandom_range(0, int'(per) + 5));
                if ($urandom_range(0, 9) != 0)
                    rep = mlbc_pkg::SHORT_W'($urandom_range(0, 6));
            end
            else if (pick < 95)
            begin
                cmd = mlbc_pkg::CMD_W'($urandom_range(mlbc_pkg::CMD_OFF,
                                                      mlbc_pkg::CMD_TOGGLE));
            end
            else
            begin
                cmd = mlbc_pkg::CMD_W'($urandom_range(int'(mlbc_pkg::CMD_POLL) + 1,
                                                      int'(CMD_RSVD_LAST)));
            end
        end
        send_request(cmd, sel, on_t, per, rep, t);
    endtask

    // Result side: random stall after each result, plus the long hold-off.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                levels.check_levels(led_levels);
                stall_left = rx_burst ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 39) == 0)
                    rx_burst = ~rx_burst;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= out_hold || (stall_left > 0);
        end
    end

    initial
    begin
        out_hold = 1'b0;
        wait (hold_go);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int c;
        in_valid     = 1'b0;
        command      = mlbc_pkg::CMD_OFF;
        led_select   = '0;
        on_time      = '0;
        blink_period = '0;
        repeat_count = '0;
        now          = '0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        hold_go      = 1'b0;
        wall_clock   = '0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: manual control, extremes, wrap, zero period, endless, last repeat
        send_request(mlbc_pkg::CMD_ON,     2'd0, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_TOGGLE, 2'd1, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_OFF,    2'd0, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_TOGGLE, 2'd1, '1, '1, '1, '1);
        send_request(mlbc_pkg::CMD_BLINK,  2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        send_request(mlbc_pkg::CMD_BLINK,  2'd1, 16'd3, 16'd10, 16'd2, 32'hFFFF_FFF8);
        send_request(mlbc_pkg::CMD_BLINK,  2'd2, 16'd5, 16'd0, 16'd1, 32'd100);
        send_request(mlbc_pkg::CMD_BLINK,  2'd3, 16'd2, 16'd4, 16'd0, 32'd100);
        for (c = int'(mlbc_pkg::CMD_POLL) + 1; c <= int'(CMD_RSVD_LAST); c++)
            send_request(mlbc_pkg::CMD_W'(c), 2'd3, '1, '1, '1, '1);
        send_request(mlbc_pkg::CMD_TOGGLE, 2'd3, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_POLL,   2'd2, '0, '0, '0, 32'd103);
        send_request(mlbc_pkg::CMD_POLL,   2'd1, '0, '0, '0, 32'd110);
        send_request(mlbc_pkg::CMD_POLL,   2'd0, '0, '0, '0, 32'd114);
        send_request(mlbc_pkg::CMD_OFF,    2'd3, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_ON,     2'd2, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_POLL,   2'd3, '0, '0, '0, 32'hFFFF_FFFF);
        send_request(mlbc_pkg::CMD_POLL,   2'd0, '0, '0, '0, 32'd0);
        send_request(mlbc_pkg::CMD_ON,     2'd3, '0, '0, '0, '0);
        send_request(mlbc_pkg::CMD_POLL,   2'd1, '0, '0, '0, 32'd200);

        wall_clock = 32'd1000;
        repeat (600) send_random_request();

        // receiver holds off while requests keep coming back to back
        tx_burst = 1'b1;
        hold_go  = 1'b1;
        repeat (100) send_random_request();
        tx_burst = 1'b0;

        // clock starts just below the 32-bit wrap
        wall_clock = 32'hFFFF_F000;
        repeat (700) send_random_request();

        in_valid <= 1'b0;
        while (levels.levels_due.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (levels.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
